// File: rtl/olir_pkg.sv
// Shared types and constants for the ordered list block.
// No dependencies; the top, front end and back end import this package.
`default_nettype none

package olir_pkg;

  // Default sizes of the list store
  localparam int unsigned CapacityDef  = 16;
  localparam int unsigned DataWidthDef = 32;

  // Fixed widths of the result fields
  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 5;

  // Depth of the command queue and of the result queue
  localparam int unsigned QueueDepth = 2;

  // Operation codes as they arrive on the input
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LIST   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // Sequencer states of the back end
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PEEK,
    ST_WALK,
    ST_REPORT
  } back_state_e;

  // One result item
  typedef struct packed {
    logic [ValueW-1:0] entry_value;
    logic              entry_valid;
    logic              last_result;
    logic              found;
    logic              insert_refused;
    logic [CountW-1:0] entry_count;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/ordered_list_insert_remove_top.sv
// Top level of the ordered list: front end, back end and result queue.
// Depends on olir_pkg, olir_front, olir_back and olir_fifo.
//
//   Channel   Handshake          Accepted when       Payload
//   input     push / full        push && !full       operation_i, value_i
//   result    empty / pop        pop && !empty       entry_value_o ... entry_count_o
//
// Insert, an unused code, and remove or list-out on an empty list are
// handled straight from idle. Remove checks the newest entry first and
// otherwise walks the list store, as list-out does, one read port word a
// cycle; a full result queue holds the list-out walk. Reset clears the
// occupancy and all control state; stored entries are not cleared. A full
// result queue stalls the back end, and a full command queue holds full
// high; each side stalls on its own.
`default_nettype none

module ordered_list_insert_remove_top
  import olir_pkg::*;
#(
  parameter int unsigned CAPACITY   = CapacityDef,
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     push,
  output logic                          full,
  input  wire logic        [1:0]        operation_i,
  input  wire logic signed [ValueW-1:0] value_i,
  output logic                          empty,
  input  wire logic                     pop,
  output logic signed      [ValueW-1:0] entry_value_o,
  output logic                          entry_valid_o,
  output logic                          last_result_o,
  output logic                          found_o,
  output logic                          insert_refused_o,
  output logic             [CountW-1:0] entry_count_o
);

  logic                  cmd_valid, cmd_pop;
  op_e                   cmd_op;
  logic [DATA_WIDTH-1:0] cmd_value;
  logic                  res_push, res_full;
  res_t                  res_in, res_out;

  // Accept and classify items
  olir_front #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .operation_i (operation_i),
    .value_i     (value_i),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_op_o    (cmd_op),
    .cmd_value_o (cmd_value)
  );

  // Carry out commands on the list store
  olir_back #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_op_i    (cmd_op),
    .cmd_value_i (cmd_value),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // Queue results for the consumer
  olir_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (QueueDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .full_o  (res_full),
    .data_i  (res_in),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (res_out)
  );

  assign entry_value_o    = res_out.entry_value;
  assign entry_valid_o    = res_out.entry_valid;
  assign last_result_o    = res_out.last_result;
  assign found_o          = res_out.found;
  assign insert_refused_o = res_out.insert_refused;
  assign entry_count_o    = res_out.entry_count;

endmodule

`default_nettype wire

// File: rtl/olir_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module olir_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one word
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Register the read word; hold it while no read is issued
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/olir_fifo.sv
// Small synchronous queue of flat words, used for commands and results.
// No dependencies.
`default_nettype none

module olir_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  output logic                  full_o,
  input  wire logic [WIDTH-1:0] data_i,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output logic      [WIDTH-1:0] data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FillW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             do_push, do_pop;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] ptr);
    next_ptr = (ptr == PtrW'(DEPTH - 1)) ? '0 : ptr + PtrW'(1);
  endfunction

  assign full_o  = (fill_q == FillW'(DEPTH));
  assign empty_o = (fill_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = do_push ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? next_ptr(rd_ptr_q) : rd_ptr_q;
    fill_d   = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + FillW'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - FillW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/olir_front.sv
// Front end: accepts items, decodes the operation, sign-extends or trims the
// value to the stored width and queues the command. Depends on olir_pkg and olir_fifo.
`default_nettype none

module olir_front
  import olir_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [1:0]            operation_i,
  input  wire logic [ValueW-1:0]     value_i,
  output logic                       cmd_valid_o,
  input  wire logic                  cmd_pop_i,
  output op_e                        cmd_op_o,
  output logic      [DATA_WIDTH-1:0] cmd_value_o
);

  localparam int unsigned CmdW = 2 + DATA_WIDTH;

  logic [ValueW+DATA_WIDTH-1:0] value_ext;
  op_e                          op_dec;
  logic [CmdW-1:0]              cmd_in, cmd_out;
  logic                         cmd_empty;

  // Classify the operation and keep the low DATA_WIDTH bits of the value
  assign op_dec    = op_e'(operation_i);
  assign value_ext = {{DATA_WIDTH{value_i[ValueW-1]}}, value_i};
  assign cmd_in    = {op_dec, value_ext[DATA_WIDTH-1:0]};

  olir_fifo #(
    .WIDTH (CmdW),
    .DEPTH (QueueDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .data_i  (cmd_in),
    .pop_i   (cmd_pop_i),
    .empty_o (cmd_empty),
    .data_o  (cmd_out)
  );

  // Unpack the queued command
  assign cmd_valid_o = !cmd_empty;
  assign cmd_op_o    = op_e'(cmd_out[CmdW-1:DATA_WIDTH]);
  assign cmd_value_o = cmd_out[DATA_WIDTH-1:0];

endmodule

`default_nettype wire

// File: rtl/olir_back.sv
// Back end: runs queued commands on the list store, walking the entries one a
// cycle for remove and list-out (if results fit). Depends on olir_pkg, olir_ram.
`default_nettype none

module olir_back
  import olir_pkg::*;
#(
  parameter int unsigned CAPACITY   = CapacityDef,
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cmd_valid_i,
  input  wire op_e                   cmd_op_i,
  input  wire logic [DATA_WIDTH-1:0] cmd_value_i,
  output logic                       cmd_pop_o,
  input  wire logic                  res_full_i,
  output logic                       res_push_o,
  output res_t                       res_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  back_state_e           state_q, state_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [CntW-1:0]       idx_q, idx_d;
  logic [CntW-1:0]       pidx_q, pidx_d;
  logic                  pend_q, pend_d;
  logic                  found_q, found_d;
  op_e                   op_q, op_d;
  logic [DATA_WIDTH-1:0] value_q, value_d;

  logic                  ram_we, ram_re;
  logic [IdxW-1:0]       ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  logic                  is_list, consume, issue, walk_last, rd_match;
  logic                  start_walk, single;
  logic [CntW-1:0]       newest_idx, pidx_prev, res_cnt;
  logic [CntW+CountW-1:0]        cnt_ext;
  logic [DATA_WIDTH+ValueW-1:0]  val_ext;

  olir_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_en_i   (ram_re),
    .rd_addr_i (ram_raddr),
    .rd_data_o (ram_rdata)
  );

  // Walk control: a pending read word is used at once on remove, on list-out once the result side allows
  assign is_list    = (op_q == OP_LIST);
  assign consume    = (state_q == ST_WALK) && pend_q && (!is_list || !res_full_i);
  assign issue      = (state_q == ST_WALK) && (idx_q < count_q) && (!pend_q || consume);
  assign newest_idx = count_q - CntW'(1);
  assign pidx_prev  = pidx_q - CntW'(1);
  assign walk_last  = consume && (pidx_q == newest_idx);
  assign rd_match   = (ram_rdata == value_q);

  // Remove and list-out on a non-empty list need a walk; all else is one step
  assign start_walk = (state_q == ST_IDLE) && cmd_valid_i && (count_q != '0) &&
                      ((cmd_op_i == OP_REMOVE) || (cmd_op_i == OP_LIST));
  assign single     = (state_q == ST_IDLE) && cmd_valid_i && !start_walk;

  // Widen the count and the entry for the fixed-width result fields
  assign cnt_ext = {{CountW{1'b0}}, res_cnt};
  assign val_ext = {{ValueW{ram_rdata[DATA_WIDTH-1]}}, ram_rdata};

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_walk) begin
          state_d = (cmd_op_i == OP_REMOVE) ? ST_PEEK : ST_WALK;
        end
      end
      ST_PEEK: begin
        state_d = rd_match ? ST_REPORT : ST_WALK;
      end
      ST_WALK: begin
        if (walk_last) begin
          state_d = is_list ? ST_IDLE : ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (!res_full_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath, store access and result formation
  always_comb begin
    count_d    = count_q;
    idx_d      = idx_q;
    pidx_d     = pidx_q;
    pend_d     = pend_q;
    found_d    = found_q;
    op_d       = op_q;
    value_d    = value_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = count_q[IdxW-1:0];
    ram_wdata  = cmd_value_i;
    ram_re     = 1'b0;
    ram_raddr  = idx_q[IdxW-1:0];
    res_cnt    = count_q;
    res_o      = '0;

    case (state_q)
      ST_IDLE: begin
        if (single && !res_full_i) begin
          cmd_pop_o         = 1'b1;
          res_push_o        = 1'b1;
          res_o.last_result = 1'b1;
          if (cmd_op_i == OP_INSERT) begin
            if (count_q == CntW'(CAPACITY)) begin
              res_o.insert_refused = 1'b1;
            end else begin
              ram_we  = 1'b1;
              count_d = count_q + CntW'(1);
              res_cnt = count_d;
            end
          end
        end
        if (start_walk) begin
          cmd_pop_o = 1'b1;
          op_d      = cmd_op_i;
          value_d   = cmd_value_i;
          found_d   = 1'b0;
          pend_d    = 1'b0;
          idx_d     = '0;
          // Remove compares the newest entry first
          if (cmd_op_i == OP_REMOVE) begin
            ram_re    = 1'b1;
            ram_raddr = newest_idx[IdxW-1:0];
          end
        end
      end
      ST_PEEK: begin
        // Newest entry matches: drop it, no shift needed
        if (rd_match) begin
          found_d = 1'b1;
          count_d = count_q - CntW'(1);
        end
      end
      ST_WALK: begin
        if (issue) begin
          ram_re = 1'b1;
          idx_d  = idx_q + CntW'(1);
          pend_d = 1'b1;
          pidx_d = idx_q;
        end else if (consume) begin
          pend_d = 1'b0;
        end
        if (consume) begin
          if (is_list) begin
            res_push_o        = 1'b1;
            res_o.entry_valid = 1'b1;
            res_o.entry_value = val_ext[ValueW-1:0];
            res_o.last_result = walk_last;
          end else if (found_q) begin
            // Close the gap: move each later entry down by one
            ram_we    = 1'b1;
            ram_waddr = pidx_prev[IdxW-1:0];
            ram_wdata = ram_rdata;
          end else if (rd_match) begin
            found_d = 1'b1;
          end
        end
        if (walk_last && !is_list && found_d) begin
          count_d = count_q - CntW'(1);
        end
      end
      ST_REPORT: begin
        if (!res_full_i) begin
          res_push_o        = 1'b1;
          res_o.last_result = 1'b1;
          res_o.found       = found_q;
        end
      end
      default: begin
      end
    endcase

    res_o.entry_count = cnt_ext[CountW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      idx_q   <= '0;
      pidx_q  <= '0;
      pend_q  <= 1'b0;
      found_q <= 1'b0;
      op_q    <= OP_NONE;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      pidx_q  <= pidx_d;
      pend_q  <= pend_d;
      found_q <= found_d;
      op_q    <= op_d;
    end
  end

  // Hold the value under search
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

`default_nettype wire
